// ===== hdl/pol_pkg.sv =====
// ----------------------------------------------------------------------------
// pol_pkg - shared types and constants for the positional ordered list
// Request codes, result status codes, cell control word and FSM states.
// ----------------------------------------------------------------------------
package pol_pkg;

   localparam int DEF_CAPACITY = 64;
   localparam int VALUE_W      = 32;
   localparam int FUNC_W       = 3;
   localparam int POS_W        = 8;
   // cell index / count as seen by a cell; the user must see that CAPACITY never exceeds 255; nothing enforces it
   localparam int IDX_W        = 8;
   // wide enough for position, count and count+1 without wrap
   localparam int CMP_W        = 9;

   typedef enum logic [FUNC_W-1:0] {
      FN_INS_FRONT = 3'd0,
      FN_INS_END   = 3'd1,
      FN_INS_POS   = 3'd2,
      FN_DEL_FRONT = 3'd3,
      FN_DEL_END   = 3'd4,
      FN_DEL_POS   = 3'd5,
      FN_SEARCH    = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_IGNORED   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   // broadcast to every cell each cycle
   typedef struct packed {
      op_type               op;
      logic [IDX_W-1:0]     idx;    // target slot of insert/delete
      logic [IDX_W-1:0]     cnt;    // live entries, masks the compare
      logic [VALUE_W-1:0]   value;  // value to insert or search key
   } cell_ctrl_type;

endpackage

// ===== hdl/positional_ordered_list.sv =====
// ----------------------------------------------------------------------------
// positional_ordered_list - ordered list of signed 32-bit values
// A row of CAPACITY slot cells that shift left or right together, with a
// first-match encoder for searches and one result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request transaction (func, value, position); rsp_*
//   returns exactly one result transaction per request (status, found,
//   found_position, entry_count). A transaction moves on a rising edge with
//   valid high and stall low.
// Result timing:
//   Insert, delete and unused codes: the result is loaded into the output register
//   at acceptance; one transaction per cycle while the receiver keeps up.
//   Search: the cells compare in the accept cycle and register their match flags;
//   the encoder then works on those flags in state S_SCAN, during which req_stall
//   is high, so no new request is taken until the search result is loaded.
// Stall:
//   The result sits in the output register; a new request is taken only when no
//   search is in S_SCAN and that register is empty or is drained in the same cycle.
// Reset:
//   Clears the entry count, the FSM and rsp_valid. Slot contents are not
//   cleared; only slots below the count are ever compared or returned.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
   parameter int CAPACITY = pol_pkg::DEF_CAPACITY,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pol_pkg::FUNC_W-1:0]    req_func,
   input  logic signed [pol_pkg::VALUE_W-1:0] req_value,
   input  logic [pol_pkg::POS_W-1:0]     req_position,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_found,
   output logic [CNT_W-1:0]              rsp_found_position,
   output logic [CNT_W-1:0]              rsp_entry_count
);
   import pol_pkg::*;

   // control state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // result payload
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]    rsp_fpos_ff, rsp_fpos_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                accept;
   logic                rsp_load;

   // decode
   op_type              dec_op;
   status_type          dec_status;
   logic                dec_search;
   logic [CMP_W-1:0]    dec_k;
   logic [CMP_W-1:0]    cnt_w, pos_w, cap_w;

   // cell row
   cell_ctrl_type       ctrl;
   logic [VALUE_W-1:0]  entry [CAPACITY];
   logic [CAPACITY-1:0] match;
   logic                enc_hit;
   logic [CNT_W-1:0]    enc_pos;

   // take a request only when not scanning and the result register is free this cycle
   assign req_stall = (state_ff == S_SCAN) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign cnt_w = CMP_W'(count_ff);
   assign pos_w = CMP_W'(req_position);
   assign cap_w = CMP_W'(CAPACITY);

   // request decode: which slot opens or closes, and the status
   always_comb begin
      dec_op     = OP_HOLD;
      dec_status = ST_DONE;
      dec_search = 1'b0;
      dec_k      = '0;
      unique case (req_func) inside
         FN_INS_FRONT, FN_INS_END, FN_INS_POS: begin
            if (cnt_w == cap_w) begin
               dec_status = ST_FULL;
            end else begin
               dec_op = OP_INSERT;
               if (req_func == FN_INS_FRONT) begin
                  dec_k = '0;
               end else if (req_func == FN_INS_END) begin
                  dec_k = cnt_w;
               end else if (pos_w == CMP_W'(1)) begin
                  dec_k = '0;
               end else if (pos_w == '0) begin
                  // position zero lands after the front entry
                  if (cnt_w == '0) begin
                     dec_op     = OP_HOLD;
                     dec_status = ST_IGNORED;
                  end else begin
                     dec_k = CMP_W'(1);
                  end
               end else if (pos_w > cnt_w + CMP_W'(1)) begin
                  dec_op     = OP_HOLD;
                  dec_status = ST_IGNORED;
               end else begin
                  dec_k = pos_w - CMP_W'(1);
               end
            end
         end
         FN_DEL_FRONT, FN_DEL_END, FN_DEL_POS: begin
            if (cnt_w == '0) begin
               dec_status = ST_IGNORED;
            end else begin
               dec_op = OP_DELETE;
               if (req_func == FN_DEL_FRONT) begin
                  dec_k = '0;
               end else if (req_func == FN_DEL_END) begin
                  dec_k = cnt_w - CMP_W'(1);
               end else if (pos_w <= CMP_W'(1)) begin
                  dec_k = '0;
               end else if (pos_w > cnt_w) begin
                  dec_op     = OP_HOLD;
                  dec_status = ST_IGNORED;
               end else begin
                  dec_k = pos_w - CMP_W'(1);
               end
            end
         end
         FN_SEARCH: begin
            dec_search = 1'b1;
         end
         default: begin
            dec_status = ST_IGNORED;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept && dec_search) state_in = S_SCAN;
         S_SCAN: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs: cell control, count and result register
   always_comb begin
      ctrl.op       = OP_HOLD;
      ctrl.idx      = IDX_W'(dec_k);
      ctrl.cnt      = IDX_W'(count_ff);
      ctrl.value    = req_value;
      count_in      = count_ff;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_count_in  = rsp_count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctrl.op = dec_op;
               if (dec_op == OP_INSERT)      count_in = count_ff + CNT_W'(1);
               else if (dec_op == OP_DELETE) count_in = count_ff - CNT_W'(1);
               if (!dec_search) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = dec_status;
                  rsp_found_in  = 1'b0;
                  rsp_fpos_in   = '0;
                  rsp_count_in  = count_in;
               end
            end
         end
         S_SCAN: begin
            rsp_load      = 1'b1;
            rsp_status_in = enc_hit ? ST_DONE : ST_NOT_FOUND;
            rsp_found_in  = enc_hit;
            rsp_fpos_in   = enc_pos;
            rsp_count_in  = count_ff;
         end
         default: ;
      endcase
      if (rsp_load)        rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // slot row: slots past the target take slot i-1 on insert; slots at or past it take slot i+1 on delete
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] prev_entry, next_entry;
      if (i == 0) begin : g_head
         assign prev_entry = '0;
      end else begin : g_body
         assign prev_entry = entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign next_entry = '0;
      end else begin : g_link
         assign next_entry = entry[i+1];
      end
      pol_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (entry[i]),
         .hit        (match[i])
      );
   end

   pol_first #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_first (
      .match    (match),
      .hit      (enc_hit),
      .position (enc_pos)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_entry_count    = rsp_count_ff;

endmodule

// ===== hdl/pol_cell.sv =====
// ----------------------------------------------------------------------------
// pol_cell - one slot of the list
// Holds one entry; shifts from its left or right neighbor on insert/delete
// and registers an equality flag against the broadcast key.
// ----------------------------------------------------------------------------
module pol_cell #(
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  pol_pkg::cell_ctrl_type        ctrl,
   input  logic [pol_pkg::VALUE_W-1:0]   prev_entry,
   input  logic [pol_pkg::VALUE_W-1:0]   next_entry,
   output logic [pol_pkg::VALUE_W-1:0]   entry,
   output logic                          hit
);
   import pol_pkg::*;

   logic [VALUE_W-1:0] entry_ff, entry_in;
   logic               hit_ff, hit_in;
   logic               at_k, past_k;

   assign at_k   = (ctrl.idx == IDX_W'(INDEX));
   assign past_k = (ctrl.idx <  IDX_W'(INDEX));

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (at_k)        entry_in = ctrl.value;
            else if (past_k) entry_in = prev_entry;
         end
         OP_DELETE: begin
            if (at_k || past_k) entry_in = next_entry;
         end
         default: entry_in = entry_ff;
      endcase
   end

   // only slots below the count take part in a search
   assign hit_in = (IDX_W'(INDEX) < ctrl.cnt) && (entry_ff == ctrl.value);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

// ===== hdl/pol_first.sv =====
// ----------------------------------------------------------------------------
// pol_first - first-match encoder
// Turns the registered per-slot match flags into the 1-based position of the
// lowest matching slot.
// ----------------------------------------------------------------------------
module pol_first #(
   parameter int CAPACITY = pol_pkg::DEF_CAPACITY,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic [CAPACITY-1:0] match,
   output logic                hit,
   output logic [CNT_W-1:0]    position
);
   import pol_pkg::*;

   logic [CAPACITY-1:0] first;

   assign first[0] = match[0];
   for (genvar i = 1; i < CAPACITY; i++) begin : g_first
      assign first[i] = match[i] && !(|match[i-1:0]);
   end

   always_comb begin
      position = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first[i]) position = position | CNT_W'(i + 1);
      end
   end

   assign hit = |match;

endmodule

// ===== hdl/pol_checker.sv =====
// ----------------------------------------------------------------------------
// pol_checker - port-level checks for the positional ordered list
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module pol_checker #(
   parameter int CAPACITY = pol_pkg::DEF_CAPACITY,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [1:0]       rsp_status,
   input logic             rsp_found,
   input logic [CNT_W-1:0] rsp_found_position,
   input logic [CNT_W-1:0] rsp_entry_count
);
   import pol_pkg::*;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CNT_W'(CAPACITY)))
      else $error("entry count above capacity");

   a_found_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         (rsp_status == ST_DONE) && (rsp_found_position != '0)
         && (rsp_found_position <= rsp_entry_count))
      else $error("match reported without valid position");

   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_found_position == '0))
      else $error("position set without a match");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_entry_count == CNT_W'(CAPACITY)))
      else $error("full status with list not full");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_count) && $stable(rsp_found_position))
      else $error("stalled result changed");

endmodule

bind positional_ordered_list pol_checker #(
   .CAPACITY (CAPACITY),
   .CNT_W    (CNT_W)
) u_pol_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_found          (rsp_found),
   .rsp_found_position (rsp_found_position),
   .rsp_entry_count    (rsp_entry_count)
);
